@@ src/csvt_pkg.sv @@
// shared types and constants of the csv field tokenizer
package csvt_pkg;

    // bytes with a meaning to the tokenizer
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // error codes carried with each result
    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_MALFORMED    = 2'd1,
        ERR_UNTERMINATED = 2'd2
    } t_csvt_err;

    // per-line quoting state
    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic after_close;
        logic field_is_empty;
        logic line_failed;
    } t_csvt_state;

    localparam t_csvt_state CSVT_STATE_CLEAR = '{
        in_quotes:      1'b0,
        quote_pending:  1'b0,
        after_close:    1'b0,
        field_is_empty: 1'b1,
        line_failed:    1'b0
    };

    // one result item
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       field_end;
        logic       line_end;
        t_csvt_err  error_code;
    } t_csvt_result;

endpackage

@@ src/csvt_if.sv @@
// valid/ready channels for line bytes in and tokens out

interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       line_last;

    modport source (output valid, output in_char, output line_last, input ready);
    modport sink   (input valid, input in_char, input line_last, output ready);
endinterface

interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       field_end;
    logic       line_end;
    logic [1:0] error_code;

    modport source (
        output valid, output char_valid, output out_char, output field_end,
        output line_end, output error_code, input ready
    );
    modport sink (
        input valid, input char_valid, input out_char, input field_end,
        input line_end, input error_code, output ready
    );
endinterface

@@ src/csvt_step.sv @@
// one-byte step of the quoting state machine: next state and result
module csvt_step (
    input  csvt_pkg::t_csvt_state  i_state,
    input  logic [7:0]             i_char,
    input  logic                   i_last,
    output csvt_pkg::t_csvt_state  o_state_next,
    output csvt_pkg::t_csvt_result o_result
);
    import csvt_pkg::*;

    t_csvt_state  n;
    t_csvt_result res;
    logic         handled;
    logic         is_quote;
    logic         is_comma;

    assign is_quote = (i_char == CH_QUOTE);
    assign is_comma = (i_char == CH_COMMA);

    always_comb begin
        n       = i_state;
        res     = '0;
        handled = 1'b0;

        if (!i_state.line_failed) begin
            // quoted field: pending quote resolves first, then quoted bytes
            if (i_state.quote_pending) begin
                n.quote_pending = 1'b0;
                if (is_quote) begin
                    res.char_valid   = 1'b1;
                    res.out_char     = CH_QUOTE;
                    n.field_is_empty = 1'b0;
                    handled          = 1'b1;
                end else begin
                    n.in_quotes   = 1'b0;
                    n.after_close = 1'b1;
                end
            end else if (i_state.in_quotes) begin
                if (is_quote) begin
                    if (i_last) begin
                        n.in_quotes   = 1'b0;
                        n.after_close = 1'b1;
                    end else begin
                        n.quote_pending = 1'b1;
                    end
                end else begin
                    res.char_valid   = 1'b1;
                    res.out_char     = i_char;
                    n.field_is_empty = 1'b0;
                end
                handled = 1'b1;
            end

            // unquoted bytes and bytes after a closing quote
            if (!handled) begin
                if (is_comma) begin
                    res.field_end    = 1'b1;
                    n.field_is_empty = 1'b1;
                    n.after_close    = 1'b0;
                end else if (is_quote && n.field_is_empty && !n.after_close) begin
                    n.in_quotes = 1'b1;
                end else if ((i_char == CH_CR) && i_last) begin
                    // final carriage return dropped
                end else if (n.after_close || is_quote) begin
                    res.error_code = ERR_MALFORMED;
                    n.line_failed  = 1'b1;
                end else begin
                    res.char_valid   = 1'b1;
                    res.out_char     = i_char;
                    n.field_is_empty = 1'b0;
                end
            end

            // quotes still open when the line ends
            if (i_last && !n.line_failed && n.in_quotes) begin
                res.error_code = ERR_UNTERMINATED;
            end
        end

        // line end closes the last field and clears all state
        if (i_last) begin
            res.line_end = 1'b1;
            n            = CSVT_STATE_CLEAR;
        end
    end

    assign o_state_next = n;
    assign o_result     = res;

endmodule

@@ src/csv_field_tokenizer_core.sv @@
// top level of the csv field tokenizer: input register, step logic, result register
//
// Usage: i_in carries one byte of a text line per transfer, with line_last
// set on the final byte of the line. o_out gives one result per byte: an
// optional field byte (char_valid/out_char), field_end when a comma closes a
// field, line_end on the final byte of a line and error_code for quoting
// errors. A line holds one more field than it has field_end marks.
// Path: a byte taken from i_in is registered, run through the step logic and
// loaded into the result register; its result is on o_out from then on.
// Throughput is one byte per cycle while o_out is not stalled; the only loop
// is the five-bit quoting state, updated in the same cycle as the result register.
// Stall: when o_out.ready is low the result register holds; the input
// register still takes one more byte, and i_in.ready drops only when both
// are full, so no byte is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// quoting state to the start of a line.
module csv_field_tokenizer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csvt_in_if.sink         i_in,
    csvt_out_if.source      o_out
);
    import csvt_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    t_csvt_state  r_state;
    t_csvt_state  n_state;
    logic         r_out_valid;
    t_csvt_result r_out;
    t_csvt_result n_out;
    logic         out_free;
    logic         step_go;

    // handshake: the result register frees up when empty or taken
    assign out_free   = !r_out_valid || o_out.ready;
    assign step_go    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    csvt_step u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .o_state_next (n_state),
        .o_result     (n_out)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= CSVT_STATE_CLEAR;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (step_go) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.in_char;
            r_in_last <= i_in.line_last;
        end
        if (step_go) begin
            r_out <= n_out;
        end
    end

    // result port
    assign o_out.valid      = r_out_valid;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.out_char   = r_out.out_char;
    assign o_out.field_end  = r_out.field_end;
    assign o_out.line_end   = r_out.line_end;
    assign o_out.error_code = r_out.error_code;

`ifndef SYNTHESIS
    // the last byte of a line leaves the state at the start of a line
    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && r_in_last) |=> (r_state == CSVT_STATE_CLEAR))
        else $error("state not cleared after line end");

    // a pending quote only exists inside quotes
    a_pending_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.quote_pending |-> r_state.in_quotes)
        else $error("quote pending outside quotes");

    // after a closing quote or an error the field is no longer quoted
    a_closed_not_quoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.after_close || r_state.line_failed) |-> !r_state.in_quotes)
        else $error("quoted state after close or failure");

    // a malformed result carries neither a byte nor a field end
    a_malformed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_code == ERR_MALFORMED))
            |-> (!r_out.char_valid && !r_out.field_end))
        else $error("malformed result with field data");
`endif

endmodule
